// ----- hdl/ppt_pkg.sv -----
package ppt_pkg;

	localparam int MAX_DIMENSION_DEF = 16;

	localparam int DIM_W   = 5;
	localparam int MODE_W  = 3;
	localparam int POS_W   = 8;
	localparam int VAL_W   = 8;
	localparam int CNT_W   = 5;
	localparam int ENTRY_W = VAL_W + 1;

	localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

	localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EXTEND    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd4;

endpackage

// ----- hdl/ppt_ram.sv -----
module ppt_ram #(
	parameter int WIDTH = ppt_pkg::ENTRY_W,
	parameter int DEPTH = ppt_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/partial_permutation_table_core.sv -----
// channel    | handshake                 | payload
// -----------+---------------------------+------------------------------------------
// item in    | start, busy               | mode, position, value
// result out | done (one-cycle strobe)   | read_value, read_defined, index_error,
//            |                           | extended, legal, complete,
//            |                           | undefined_count, least_unused, least_valid
// config     | dim_valid, dim_ready      | dimension
//
// an item runs from its accepting edge to done through an update state, a sweep of
// the table ram over the effective dimension that drains its read pipeline, then a
// walk of the used-value flags up to the least unused value. a read adds a wait
// state for the ram's registered read port; an extend that fills adds a write state
// and a second sweep and walk.
// arst_n clears control state, the entry valid flags and sets dimension to 16.
// the receiver cannot stall: done is high for exactly one cycle, and a new item
// may be started in that same cycle.
module partial_permutation_table_core #(
	parameter int MAX_DIMENSION = ppt_pkg::MAX_DIMENSION_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ppt_pkg::MODE_W-1:0] mode,
	input  logic [ppt_pkg::POS_W-1:0]  position,
	input  logic [ppt_pkg::VAL_W-1:0]  value,
	output logic                       done,
	output logic [ppt_pkg::VAL_W-1:0]  read_value,
	output logic                       read_defined,
	output logic                       index_error,
	output logic                       extended,
	output logic                       legal,
	output logic                       complete,
	output logic [ppt_pkg::CNT_W-1:0]  undefined_count,
	output logic [ppt_pkg::CNT_W-1:0]  least_unused,
	output logic                       least_valid,
	input  logic                       dim_valid,
	output logic                       dim_ready,
	input  logic [ppt_pkg::DIM_W-1:0]  dimension
);

	localparam int AW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
	localparam int CW = $clog2(MAX_DIMENSION + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OP   = 3'd1;
	localparam logic [2:0] S_RDW  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MEX  = 3'd4;
	localparam logic [2:0] S_EXT  = 3'd5;

	logic [2:0]                   state_q;
	logic [ppt_pkg::DIM_W-1:0]    dim_q;
	logic [ppt_pkg::MODE_W-1:0]   mode_q;
	logic [ppt_pkg::POS_W-1:0]    pos_q;
	logic [ppt_pkg::VAL_W-1:0]    val_q;
	logic [CW-1:0]                n_q;
	logic                         ierr_q;
	logic                         ext_q;
	logic                         ext_pend_q;
	logic [ppt_pkg::VAL_W-1:0]    rv_q;
	logic                         rd_q;
	logic [MAX_DIMENSION-1:0]     vld_q;
	logic [MAX_DIMENSION-1:0]     used_q;
	logic [CW-1:0]                scan_q;
	logic [CW-1:0]                undef_q;
	logic [CW-1:0]                mex_q;
	logic                         legal_q;
	logic [AW-1:0]                fu_q;
	logic                         proc_s1;
	logic                         vld_s1;
	logic [AW-1:0]                addr_s1;
	logic                         done_q;

	logic [CW-1:0]                n_eff;
	logic                         accept;
	logic                         pos_mode;
	logic                         ierr_in;
	logic [AW-1:0]                pos_idx;
	logic                         scan_init;
	logic                         ent_def;
	logic [ppt_pkg::VAL_W-1:0]    ent_val;
	logic                         ent_in_range;
	logic                         mex_step;
	logic                         fin;
	logic                         go_ext;
	logic                         cmpl;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [ppt_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [ppt_pkg::ENTRY_W-1:0]  ram_rdata;

	ppt_ram #(
		.WIDTH (ppt_pkg::ENTRY_W),
		.DEPTH (MAX_DIMENSION)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign dim_ready = 1'b1;
	assign done      = done_q;

	// dimension clamped into 1 .. MAX_DIMENSION
	always_comb begin
		if (dim_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(dim_q) > MAX_DIMENSION) begin
			n_eff = CW'(MAX_DIMENSION);
		end else begin
			n_eff = CW'(dim_q);
		end
	end

	assign pos_mode = (mode == ppt_pkg::MODE_WRITE) || (mode == ppt_pkg::MODE_CLEAR) ||
		(mode == ppt_pkg::MODE_READ);
	assign ierr_in  = pos_mode && (32'(position) >= 32'(n_eff));
	assign pos_idx  = pos_q[AW-1:0];

	assign ent_def      = vld_s1 && ram_rdata[ppt_pkg::VAL_W];
	assign ent_val      = ram_rdata[ppt_pkg::VAL_W-1:0];
	assign ent_in_range = 32'(ent_val) < 32'(n_q);

	assign mex_step = (32'(mex_q) < 32'(n_q)) && used_q[mex_q[AW-1:0]];
	assign fin      = (state_q == S_MEX) && !mex_step;
	assign go_ext   = ext_pend_q && (undef_q == CW'(1));
	assign cmpl     = legal_q && (undef_q == '0);

	always_comb begin
		scan_init = 1'b0;
		unique case (state_q)
			S_OP:    scan_init = (mode_q != ppt_pkg::MODE_READ) || ierr_q;
			S_RDW:   scan_init = 1'b1;
			S_EXT:   scan_init = 1'b1;
			default: scan_init = 1'b0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_idx;
		ram_wdata = '0;
		ram_raddr = scan_q[AW-1:0];
		unique case (state_q)
			S_OP: begin
				if (!ierr_q) begin
					unique case (mode_q)
						ppt_pkg::MODE_WRITE: begin
							ram_we    = 1'b1;
							ram_wdata = {1'b1, val_q};
						end
						ppt_pkg::MODE_CLEAR: begin
							ram_we = 1'b1;
						end
						ppt_pkg::MODE_READ: begin
							ram_raddr = pos_idx;
						end
						ppt_pkg::MODE_CLEAR_ALL: begin
							// a one-position table clears to the identity
							if (n_q == CW'(1)) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = {1'b1, {ppt_pkg::VAL_W{1'b0}}};
							end
						end
						default: ram_we = 1'b0;
					endcase
				end
			end
			S_EXT: begin
				ram_we    = 1'b1;
				ram_waddr = fu_q;
				ram_wdata = {1'b1, ppt_pkg::VAL_W'(mex_q)};
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dim_q      <= ppt_pkg::DIM_RESET;
			vld_q      <= '0;
			done_q     <= 1'b0;
			proc_s1    <= 1'b0;
			ext_pend_q <= 1'b0;
		end else begin
			done_q <= fin && !go_ext;
			if (dim_valid && dim_ready) begin
				dim_q <= dimension;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_OP;
						ext_pend_q <= (mode == ppt_pkg::MODE_EXTEND);
					end
				end
				S_OP: begin
					if (!ierr_q) begin
						if (mode_q == ppt_pkg::MODE_WRITE || mode_q == ppt_pkg::MODE_CLEAR) begin
							vld_q[pos_idx] <= 1'b1;
						end else if (mode_q == ppt_pkg::MODE_CLEAR_ALL) begin
							vld_q <= MAX_DIMENSION'(n_q == CW'(1));
						end
					end
					state_q <= (mode_q == ppt_pkg::MODE_READ && !ierr_q) ? S_RDW : S_SCAN;
				end
				S_RDW: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					proc_s1 <= (scan_q < n_q);
					if (scan_q == n_q && !proc_s1) begin
						state_q <= S_MEX;
					end
				end
				S_MEX: begin
					if (!mex_step) begin
						if (go_ext) begin
							state_q <= S_EXT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EXT: begin
					vld_q[fu_q] <= 1'b1;
					ext_pend_q  <= 1'b0;
					state_q     <= S_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
			if (scan_init) begin
				proc_s1 <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			pos_q  <= position;
			val_q  <= value;
			n_q    <= n_eff;
			ierr_q <= ierr_in;
			ext_q  <= 1'b0;
			rv_q   <= '0;
			rd_q   <= 1'b0;
		end
		if (state_q == S_OP && !ierr_q && mode_q == ppt_pkg::MODE_WRITE) begin
			rv_q <= val_q;
			rd_q <= 1'b1;
		end
		if (state_q == S_RDW) begin
			rd_q <= vld_q[pos_idx] && ram_rdata[ppt_pkg::VAL_W];
			rv_q <= (vld_q[pos_idx] && ram_rdata[ppt_pkg::VAL_W]) ? ram_rdata[ppt_pkg::VAL_W-1:0]
				: '0;
		end
		if (state_q == S_EXT) begin
			ext_q <= 1'b1;
		end

		if (scan_init) begin
			scan_q  <= '0;
			undef_q <= '0;
			legal_q <= 1'b1;
			used_q  <= '0;
			mex_q   <= '0;
		end else if (state_q == S_SCAN) begin
			// issue side of the sweep
			if (scan_q < n_q) begin
				addr_s1 <= scan_q[AW-1:0];
				vld_s1  <= vld_q[scan_q[AW-1:0]];
				scan_q  <= scan_q + CW'(1);
			end
			// entry returned by the ram for the previous address
			if (proc_s1) begin
				if (!ent_def) begin
					undef_q <= undef_q + CW'(1);
					fu_q    <= addr_s1;
				end else if (!ent_in_range) begin
					legal_q <= 1'b0;
				end else begin
					if (used_q[ent_val[AW-1:0]]) begin
						legal_q <= 1'b0;
					end
					used_q[ent_val[AW-1:0]] <= 1'b1;
				end
			end
		end else if (state_q == S_MEX && mex_step) begin
			mex_q <= mex_q + CW'(1);
		end

		if (fin && !go_ext) begin
			read_value      <= rv_q;
			read_defined    <= rd_q;
			index_error     <= ierr_q;
			extended        <= ext_q;
			legal           <= legal_q;
			complete        <= cmpl;
			undefined_count <= ppt_pkg::CNT_W'(undef_q);
			least_unused    <= cmpl ? '0 : ppt_pkg::CNT_W'(mex_q);
			least_valid     <= !cmpl;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while an item is still in progress");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start transaction");

	a_ext_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(done && extended) |-> (undefined_count == '0))
		else $error("extend reported with positions still undefined");

	a_ierr_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (!read_defined && read_value == '0))
		else $error("read fields set on an index error");

endmodule
